/* rtl/itd_pkg.sv */
package itd_pkg;

	localparam int NUM_DIGITS    = 10;
	localparam int BITS_PER_STEP = 4;
	localparam int NUM_STEPS     = 32 / BITS_PER_STEP;

	localparam logic [5:0] CHAR_ZERO  = 6'd48;
	localparam logic [5:0] CHAR_MINUS = 6'd45;

	typedef logic [3:0] bcd_digit_t;
	typedef bcd_digit_t [NUM_DIGITS-1:0] bcd_word_t;

	// one converted value on its way to the emitter
	typedef struct packed {
		logic       neg;
		logic [3:0] ndig;
		bcd_word_t  digits;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

/* rtl/int_to_decimal_ascii.sv */
// Channel   Handshake         Payload
// input     start / busy      value (signed 32)
// output    strobe            char_code (6), last
//
// A value passes through the converter in order: accept, eight 4-bit BCD steps, queue
// push; the emitter then sends one character per cycle, 1 to 11 characters per value.
// Sustained throughput is set by whichever is slower, the converter's step count or
// the emitter's one-beat-per-cycle output; the converter takes no new value until it has pushed.
// arst_n clears the state flags, step counter and queue pointers; the queue comes up empty.
// Results cannot be held off; busy is high while the converter works or its finished value waits for room in the queue.
module int_to_decimal_ascii #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] value,
	output logic               strobe,
	output logic [5:0]         char_code,
	output logic               last
);
	import itd_pkg::*;

	queue_status_t q_status;
	entry_t        push_data;
	entry_t        pop_data;
	logic          push;
	logic          pop;

	itd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.value     (value),
		.busy      (busy),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	itd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	itd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop_data  (pop_data),
		.pop       (pop),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last)
	);

endmodule

/* rtl/itd_front.sv */
module itd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [31:0]    value,
	output logic                  busy,
	input  itd_pkg::queue_status_t q_status,
	output logic                  push,
	output itd_pkg::entry_t       push_data
);
	import itd_pkg::*;

	localparam int CNT_W = $clog2(NUM_STEPS);

	logic             active_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      mag_q;
	logic             neg_q;
	bcd_word_t        bcd_q;
	bcd_word_t        bcd_next;
	logic             accept;
	logic [31:0]      raw;

	// shift-and-add-3: one magnitude bit into the BCD word
	function automatic bcd_word_t dabble_bit(input bcd_word_t bcd, input logic bit_in);
		bcd_word_t adj;
		adj = bcd;
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (adj[d] >= 4'd5) begin
				adj[d] = adj[d] + 4'd3;
			end
		end
		return {adj[NUM_DIGITS-1][2:0], adj[NUM_DIGITS-2:0], bit_in};
	endfunction

	always_comb begin
		bcd_next = bcd_q;
		for (int b = 0; b < BITS_PER_STEP; b++) begin
			bcd_next = dabble_bit(bcd_next, mag_q[31-b]);
		end
	end

	assign raw    = value;
	assign busy   = active_q | done_q;
	assign accept = start & ~busy;
	assign push   = done_q & ~q_status.full;

	always_comb begin
		push_data.neg    = neg_q;
		push_data.digits = bcd_q;
		push_data.ndig   = 4'd1;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if (bcd_q[d] != 4'd0) begin
				push_data.ndig = 4'(d + 1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NUM_STEPS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end else if (push) begin
				done_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= raw[31];
			mag_q <= raw[31] ? (~raw + 32'd1) : raw;
			bcd_q <= '0;
		end else if (active_q) begin
			mag_q <= {mag_q[31-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
			bcd_q <= bcd_next;
		end
	end

endmodule

/* rtl/itd_fifo.sv */
module itd_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  itd_pkg::entry_t        push_data,
	input  logic                   pop,
	output itd_pkg::entry_t        pop_data,
	output itd_pkg::queue_status_t status
);
	import itd_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t           slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* rtl/itd_back.sv */
module itd_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  itd_pkg::queue_status_t q_status,
	input  itd_pkg::entry_t        pop_data,
	output logic                   pop,
	output logic                   strobe,
	output logic [5:0]             char_code,
	output logic                   last
);
	import itd_pkg::*;

	logic       active_q;
	logic       sign_q;
	logic [3:0] idx_q;
	bcd_word_t  digits_q;
	logic       finishing;
	logic [5:0] char_next;
	logic       strobe_q;
	logic [5:0] char_q;
	logic       last_q;

	assign finishing = active_q & ~sign_q & (idx_q == 4'd0);
	// next entry is popped in the same cycle that the current one forms its last character
	assign pop       = ~q_status.empty & (~active_q | finishing);
	assign char_next = sign_q ? CHAR_MINUS : CHAR_ZERO + {2'b00, digits_q[idx_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
			end else if (finishing) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		char_q <= char_next;
		last_q <= finishing;
		if (pop) begin
			sign_q   <= pop_data.neg;
			idx_q    <= pop_data.ndig - 4'd1;
			digits_q <= pop_data.digits;
		end else if (active_q) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 4'd1;
			end
		end
	end

	assign strobe    = strobe_q;
	assign char_code = char_q;
	assign last      = last_q;

endmodule
